>>> rtl/core/sbse_pkg.sv
// Shared types, constants and the biphase-mark code table for the subframe encoder.
`timescale 1ns / 1ps

package sbse_pkg;

    // Subframes in one channel-status block.
    localparam int BLOCK_SUBFRAMES_DEF = 384;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    // Fixed code bytes and aux codes of the subframe control word.
    localparam logic [7:0]  VUCP_CODE     = 8'hCC;
    localparam logic [7:0]  SYNC_CODE_B   = 8'hE8;
    localparam logic [7:0]  SYNC_CODE_M   = 8'hE2;
    localparam logic [7:0]  SYNC_CODE_W   = 8'hE4;
    localparam logic [15:0] AUX_BASE      = 16'hB333;
    localparam logic [15:0] AUX_FLIPPED   = 16'hCCCC;

    // Preamble chosen by the front part for each subframe.
    typedef enum logic [1:0] {
        PRE_KIND_M,
        PRE_KIND_W,
        PRE_KIND_B
    } pre_kind_t;

    // One classified item waiting for the back part.
    typedef struct packed {
        logic [15:0] sample;
        logic        last;
        pre_kind_t   pre;
    } q_entry_t;

    // Fill status of the queue.
    typedef struct packed {
        logic                     full;
        logic                     empty;
        logic [QUEUE_LEVEL_W-1:0] level;
    } q_status_t;

    // Biphase-mark code of each byte value.
    localparam logic [15:0] BMC_ROM [256] = '{
        16'hcccc, 16'h4ccc, 16'h2ccc, 16'haccc, 16'h34cc, 16'hb4cc, 16'hd4cc, 16'h54cc,
        16'h32cc, 16'hb2cc, 16'hd2cc, 16'h52cc, 16'hcacc, 16'h4acc, 16'h2acc, 16'haacc,
        16'h334c, 16'hb34c, 16'hd34c, 16'h534c, 16'hcb4c, 16'h4b4c, 16'h2b4c, 16'hab4c,
        16'hcd4c, 16'h4d4c, 16'h2d4c, 16'had4c, 16'h354c, 16'hb54c, 16'hd54c, 16'h554c,
        16'h332c, 16'hb32c, 16'hd32c, 16'h532c, 16'hcb2c, 16'h4b2c, 16'h2b2c, 16'hab2c,
        16'hcd2c, 16'h4d2c, 16'h2d2c, 16'had2c, 16'h352c, 16'hb52c, 16'hd52c, 16'h552c,
        16'hccac, 16'h4cac, 16'h2cac, 16'hacac, 16'h34ac, 16'hb4ac, 16'hd4ac, 16'h54ac,
        16'h32ac, 16'hb2ac, 16'hd2ac, 16'h52ac, 16'hcaac, 16'h4aac, 16'h2aac, 16'haaac,
        16'h3334, 16'hb334, 16'hd334, 16'h5334, 16'hcb34, 16'h4b34, 16'h2b34, 16'hab34,
        16'hcd34, 16'h4d34, 16'h2d34, 16'had34, 16'h3534, 16'hb534, 16'hd534, 16'h5534,
        16'hccb4, 16'h4cb4, 16'h2cb4, 16'hacb4, 16'h34b4, 16'hb4b4, 16'hd4b4, 16'h54b4,
        16'h32b4, 16'hb2b4, 16'hd2b4, 16'h52b4, 16'hcab4, 16'h4ab4, 16'h2ab4, 16'haab4,
        16'hccd4, 16'h4cd4, 16'h2cd4, 16'hacd4, 16'h34d4, 16'hb4d4, 16'hd4d4, 16'h54d4,
        16'h32d4, 16'hb2d4, 16'hd2d4, 16'h52d4, 16'hcad4, 16'h4ad4, 16'h2ad4, 16'haad4,
        16'h3354, 16'hb354, 16'hd354, 16'h5354, 16'hcb54, 16'h4b54, 16'h2b54, 16'hab54,
        16'hcd54, 16'h4d54, 16'h2d54, 16'had54, 16'h3554, 16'hb554, 16'hd554, 16'h5554,
        16'h3332, 16'hb332, 16'hd332, 16'h5332, 16'hcb32, 16'h4b32, 16'h2b32, 16'hab32,
        16'hcd32, 16'h4d32, 16'h2d32, 16'had32, 16'h3532, 16'hb532, 16'hd532, 16'h5532,
        16'hccb2, 16'h4cb2, 16'h2cb2, 16'hacb2, 16'h34b2, 16'hb4b2, 16'hd4b2, 16'h54b2,
        16'h32b2, 16'hb2b2, 16'hd2b2, 16'h52b2, 16'hcab2, 16'h4ab2, 16'h2ab2, 16'haab2,
        16'hccd2, 16'h4cd2, 16'h2cd2, 16'hacd2, 16'h34d2, 16'hb4d2, 16'hd4d2, 16'h54d2,
        16'h32d2, 16'hb2d2, 16'hd2d2, 16'h52d2, 16'hcad2, 16'h4ad2, 16'h2ad2, 16'haad2,
        16'h3352, 16'hb352, 16'hd352, 16'h5352, 16'hcb52, 16'h4b52, 16'h2b52, 16'hab52,
        16'hcd52, 16'h4d52, 16'h2d52, 16'had52, 16'h3552, 16'hb552, 16'hd552, 16'h5552,
        16'hccca, 16'h4cca, 16'h2cca, 16'hacca, 16'h34ca, 16'hb4ca, 16'hd4ca, 16'h54ca,
        16'h32ca, 16'hb2ca, 16'hd2ca, 16'h52ca, 16'hcaca, 16'h4aca, 16'h2aca, 16'haaca,
        16'h334a, 16'hb34a, 16'hd34a, 16'h534a, 16'hcb4a, 16'h4b4a, 16'h2b4a, 16'hab4a,
        16'hcd4a, 16'h4d4a, 16'h2d4a, 16'had4a, 16'h354a, 16'hb54a, 16'hd54a, 16'h554a,
        16'h332a, 16'hb32a, 16'hd32a, 16'h532a, 16'hcb2a, 16'h4b2a, 16'h2b2a, 16'hab2a,
        16'hcd2a, 16'h4d2a, 16'h2d2a, 16'had2a, 16'h352a, 16'hb52a, 16'hd52a, 16'h552a,
        16'hccaa, 16'h4caa, 16'h2caa, 16'hacaa, 16'h34aa, 16'hb4aa, 16'hd4aa, 16'h54aa,
        16'h32aa, 16'hb2aa, 16'hd2aa, 16'h52aa, 16'hcaaa, 16'h4aaa, 16'h2aaa, 16'haaaa
    };

endpackage

>>> rtl/core/sbse_front.sv
// Front part: accepts samples, runs the subframe counter and picks the preamble.
`timescale 1ns / 1ps

module sbse_front
    import sbse_pkg::*;
#(
    parameter int BLOCK_SUBFRAMES = BLOCK_SUBFRAMES_DEF,
    parameter int CNT_W           = $clog2(BLOCK_SUBFRAMES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      in_sample,
    input  logic             in_last,
    input  q_status_t        q_status,
    output logic             push,
    output q_entry_t         push_entry,
    output logic [CNT_W-1:0] count
);

    localparam logic [CNT_W:0] WRAP_AT = (CNT_W + 1)'(BLOCK_SUBFRAMES);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W:0]   count_inc;
    pre_kind_t        pre_kind;

    // Space in the queue is all the front part waits for.
    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // The count advances first; reaching the block length starts a new block.
    always_comb
    begin
        count_inc = {1'b0, count_reg} + 1'b1;
        if (count_inc >= WRAP_AT)
        begin
            pre_kind   = PRE_KIND_B;
            count_next = '0;
        end
        else
        begin
            pre_kind   = count_inc[0] ? PRE_KIND_W : PRE_KIND_M;
            count_next = count_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

    assign push_entry.sample = in_sample;
    assign push_entry.last   = in_last;
    assign push_entry.pre    = pre_kind;
    assign count             = count_reg;

endmodule

>>> rtl/core/sbse_queue.sv
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module sbse_queue
    import sbse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    q_entry_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_LEVEL_W-1:0] level_reg;

    // Entry storage; written only by the front part.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers wrap at the depth, the level tracks the difference.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (level_reg == QUEUE_LEVEL_W'(QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;

endmodule

>>> rtl/core/sbse_back.sv
// Back part: biphase-mark coding, phase fix and the registered result.
`timescale 1ns / 1ps

module sbse_back
    import sbse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_entry_t    head,
    input  q_status_t   q_status,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] data_word,
    output logic [31:0] control_word,
    output logic        block_end
);

    logic        valid_reg;
    logic [31:0] data_reg;
    logic [31:0] ctrl_reg;
    logic        last_reg;
    logic [15:0] hi_code;
    logic [15:0] lo_code;
    logic [15:0] aux_code;
    logic [7:0]  pre_byte;

    // Take the next item whenever the output register is free or draining.
    assign pop = !q_status.empty && (!valid_reg || out_ready);

    // Code both bytes; invert the low code when bit 15 of the high code is low, to keep the phase running on.
    always_comb
    begin
        hi_code  = BMC_ROM[head.sample[15:8]];
        lo_code  = BMC_ROM[head.sample[7:0]];
        if (!hi_code[15])
        begin
            lo_code = ~lo_code;
        end
        aux_code = lo_code[15] ? AUX_FLIPPED : AUX_BASE;
    end

    // Preamble byte for the chosen kind.
    always_comb
    begin
        unique case (head.pre)
            PRE_KIND_B: pre_byte = SYNC_CODE_B;
            PRE_KIND_W: pre_byte = SYNC_CODE_W;
            PRE_KIND_M: pre_byte = SYNC_CODE_M;
            default:    pre_byte = SYNC_CODE_M;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {lo_code, hi_code};
            ctrl_reg <= {VUCP_CODE, pre_byte, aux_code};
            last_reg <= head.last;
        end
    end

    assign out_valid    = valid_reg;
    assign data_word    = data_reg;
    assign control_word = ctrl_reg;
    assign block_end    = last_reg;

endmodule

>>> rtl/core/spdif_bmc_subframe_encoder.sv
// Top level of the biphase-mark subframe encoder.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_axis: one 16-bit PCM sample per item in tdata, channels
//   alternating right then left; tlast marks the final sample of a DMA block.
//   Output channel m_axis: one result item per sample. tdata carries the coded
//   data word in bits 31:0 and the control word (VUCP, preamble, aux) in bits
//   63:32; tlast repeats the input tlast.
//   Path: a sample accepted on s_axis is written into the queue and then loaded
//   into the output register, from which it is offered on m_axis.
//   Throughput: one item per cycle while m_axis_tready is high, set by the output
//   register, which loads one coded item per cycle from a two-entry queue.
//   The subframe counter picks preamble B once every BLOCK_SUBFRAMES items and
//   runs on across DMA blocks; only reset clears it.
//   Reset: the counter, the queue and the output valid are cleared.
//   Stall: while m_axis_tready is low the result holds; up to two more samples
//   are taken into the queue, after which s_axis_tready drops.

module spdif_bmc_subframe_encoder
    import sbse_pkg::*;
#(
    parameter int BLOCK_SUBFRAMES = BLOCK_SUBFRAMES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] data_word, [63:32] control_word
    output logic        m_axis_tlast
);

    localparam int CNT_W = $clog2(BLOCK_SUBFRAMES);

    logic             push;
    logic             pop;
    q_entry_t         push_entry;
    q_entry_t         head;
    q_status_t        q_status;
    logic [CNT_W-1:0] count;
    logic [31:0]      data_word;
    logic [31:0]      control_word;

    sbse_front #(
        .BLOCK_SUBFRAMES (BLOCK_SUBFRAMES),
        .CNT_W           (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry),
        .count      (count)
    );

    sbse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    sbse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .data_word    (data_word),
        .control_word (control_word),
        .block_end    (m_axis_tlast)
    );

    assign m_axis_tdata = {control_word, data_word};

`ifndef SYNTHESIS
    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= QUEUE_LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level beyond its depth");

    // The subframe count always stays inside one block.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count} < (CNT_W + 1)'(BLOCK_SUBFRAMES))
        else $error("subframe count outside the block");

    // A result appears only after an item was waiting in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!q_status.empty))
        else $error("result raised with nothing queued");

    // Nothing is taken from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from an empty queue");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for the biphase-mark subframe encoder.
`timescale 1ns / 1ps

module tb;
    import sbse_pkg::*;

    localparam int SUBFRAMES = BLOCK_SUBFRAMES_DEF;
    localparam int RANDOM_ITEMS = 1500;

    // One sample waiting to be offered, with the idle cycles that follow it.
    typedef struct {
        logic [15:0] sample;
        logic        last;
        int unsigned gap;
    } sample_item_t;

    // One coded subframe as it should leave the block.
    typedef struct {
        logic [31:0] data_word;
        logic [31:0] control_word;
        logic        block_end;
    } subframe_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;      // [15:0] sample
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [31:0] data_word, [63:32] control_word
    logic        m_axis_tlast;

    sample_item_t pending_samples[$];
    subframe_t    expected_subframes[$];
    int unsigned  subframe_cnt = 0;
    int unsigned  mismatches = 0;
    int unsigned  items_issued = 0;
    int unsigned  items_taken = 0;
    int unsigned  send_gap_left = 0;
    int unsigned  sink_stall_left = 0;
    int unsigned  cycle_no = 0;
    logic         hold_off;
    logic         sink_steady;

    spdif_bmc_subframe_encoder #(
        .BLOCK_SUBFRAMES(SUBFRAMES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // Clock with a 20 ns period.
    always #10 clk = ~clk;

    // Biphase-mark code of one byte, built backward from a final low cell.
    // Data bit k occupies code bits [15-2k:14-2k]; every bit starts with a
    // level change and a one adds a change in the middle.
    function automatic logic [15:0] bmc_byte_code(input logic [7:0] value);
        logic [15:0] code;
        logic        level;
        code = '0;
        level = 1'b0;
        for (int k = 7; k >= 0; k--)
        begin
            code[14 - 2 * k] = level;
            code[15 - 2 * k] = value[k] ? ~level : level;
            level = ~code[15 - 2 * k];
        end
        return code;
    endfunction

    // Codes one sample and advances the subframe counter.
    function automatic subframe_t encode_subframe(input logic [15:0] sample, input logic last);
        subframe_t   sf;
        logic [15:0] hi_code;
        logic [15:0] lo_code;
        logic [15:0] aux;
        logic [7:0]  preamble;
        int unsigned next_cnt;
        hi_code = bmc_byte_code(sample[15:8]);
        lo_code = bmc_byte_code(sample[7:0]);
        // Keep the phase running across the byte boundary.
        if (!hi_code[15])
            lo_code = ~lo_code;
        aux = lo_code[15] ? AUX_FLIPPED : AUX_BASE;
        next_cnt = subframe_cnt + 1;
        if (next_cnt >= SUBFRAMES)
        begin
            preamble = SYNC_CODE_B;
            subframe_cnt = 0;
        end
        else
        begin
            subframe_cnt = next_cnt;
            preamble = next_cnt[0] ? SYNC_CODE_W : SYNC_CODE_M;
        end
        sf.data_word = {lo_code, hi_code};
        sf.control_word = {VUCP_CODE, preamble, aux};
        sf.block_end = last;
        return sf;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h, expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic add_sample(input logic [15:0] sample, input logic last,
                              input int unsigned gap);
        sample_item_t it;
        it.sample = sample;
        it.last = last;
        it.gap = gap;
        pending_samples.push_back(it);
    endtask

    // Free-running cycle count that schedules the long receiver hold-offs and steady windows.
    always @(posedge clk)
    begin
        if (rst_n)
            cycle_no <= cycle_no + 1;
    end

    assign hold_off = (cycle_no >= 600 && cycle_no < 800) ||
                      (cycle_no >= 2200 && cycle_no < 2350);
    assign sink_steady = ((cycle_no / 256) % 4) == 1;

    // Sender: offers the next item once the current one has been taken.
    always @(negedge clk)
    begin
        sample_item_t it;
        if (rst_n && items_taken == items_issued)
        begin
            if (send_gap_left > 0)
            begin
                send_gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                it = pending_samples.pop_front();
                s_axis_tdata <= it.sample;
                s_axis_tlast <= it.last;
                s_axis_tvalid <= 1'b1;
                send_gap_left = it.gap;
                items_issued++;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, steady windows and the scheduled hold-offs.
    always @(negedge clk)
    begin
        if (sink_stall_left > 0)
        begin
            sink_stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off || !rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!sink_steady)
                sink_stall_left = pick_gap();
        end
    end

    // Monitor: predicts each accepted sample and checks each result item.
    always @(posedge clk)
    begin
        subframe_t want;
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_subframes.push_back(encode_subframe(s_axis_tdata, s_axis_tlast));
            items_taken++;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_subframes.size() == 0)
            begin
                report_mismatch("unexpected item", m_axis_tdata[31:0], '0);
            end
            else
            begin
                want = expected_subframes.pop_front();
                if (m_axis_tdata[31:0] !== want.data_word)
                    report_mismatch("data_word", m_axis_tdata[31:0], want.data_word);
                if (m_axis_tdata[63:32] !== want.control_word)
                    report_mismatch("control_word", m_axis_tdata[63:32], want.control_word);
                if (m_axis_tlast !== want.block_end)
                    report_mismatch("block_end", {31'b0, m_axis_tlast}, {31'b0, want.block_end});
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial
    begin
        logic steady;
        // Directed: byte extremes, phase fix on and off, both marker values.
        add_sample(16'h0000, 1'b0, 0);
        add_sample(16'hFFFF, 1'b1, 0);
        add_sample(16'h00FF, 1'b0, 0);
        add_sample(16'hFF00, 1'b0, 1);
        add_sample(16'h8000, 1'b1, 0);
        add_sample(16'h0001, 1'b0, 0);
        add_sample(16'h0080, 1'b0, 0);
        add_sample(16'h8080, 1'b1, 2);
        add_sample(16'h5555, 1'b0, 0);
        add_sample(16'hAAAA, 1'b0, 0);
        add_sample(16'h7FFF, 1'b1, 0);
        add_sample(16'h0100, 1'b0, 0);
        add_sample(16'hFE01, 1'b0, 0);
        add_sample(16'h1234, 1'b0, 5);
        add_sample(16'hEDCB, 1'b1, 0);
        add_sample(16'h01FE, 1'b0, 0);
        add_sample(16'hC3C3, 1'b0, 0);
        add_sample(16'h3C3C, 1'b1, 0);
        // Random samples in groups; some groups run with no idling at all.
        steady = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            add_sample(16'($urandom_range(0, 65535)), ($urandom_range(0, 15) == 0),
                       steady ? 0 : pick_gap());
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_samples.size() > 0 || items_taken != items_issued ||
               expected_subframes.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
